[rtl/core/ipv4_emf_pkg.sv]
`timescale 1ns / 1ps

package ipv4_emf_pkg;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_FWD   = 1'b1;

   localparam logic [1:0] STATUS_FWD      = 2'd0;
   localparam logic [1:0] STATUS_BAD_CSUM = 2'd1;
   localparam logic [1:0] STATUS_NO_ROUTE = 2'd2;

   typedef struct packed {
      logic        opcode;
      logic [3:0]  entry_index;
      logic [31:0] entry_ip;
      logic [47:0] entry_mac;
      logic        entry_valid;
      logic [47:0] eth_dst;
      logic [47:0] eth_src;
      logic [63:0] ip_word0;
      logic [63:0] ip_word1;
      logic [31:0] ip_dst;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  out_port;
      logic [47:0] new_eth_dst;
      logic [47:0] new_eth_src;
      logic [7:0]  new_ttl;
      logic [15:0] new_checksum;
   } rsp_item_type;

   typedef struct packed {
      logic write;
      logic capture;
      logic sum;
      logic fold;
      logic scan;
      logic load;
   } dp_cmd_type;

   typedef struct packed {
      logic csum_ok;
      logic scan_done;
      logic out_free;
   } dp_status_type;

endpackage

[rtl/core/ipv4_exact_match_forwarder_top.sv]
`timescale 1ns / 1ps
// Channel   Ports                            Moves
// req       req_valid, req_ready, req_item   route write or packet header item
// rsp       rsp_valid, rsp_ready, rsp_item   forwarding result item, one per packet
//
// A route write is taken while idle and gives no result.
// A packet whose checksum fails skips the table; any other packet reads the table memory
// one slot a cycle, stopping at the first exact match.
// Reset marks every slot unwritten at once, so the table reads as zero with no clearing pass.
// A result waiting in the output register does not block new items; a packet that
// finishes while it still waits is held until rsp_ready takes the earlier one.

module ipv4_exact_match_forwarder_top #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  ipv4_emf_pkg::req_item_type req_item,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output ipv4_emf_pkg::rsp_item_type rsp_item
);
   import ipv4_emf_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type stat;

   ipv4_emf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_item.opcode),
      .req_ready  (req_ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ipv4_emf_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

[rtl/core/ipv4_emf_ctrl.sv]
`timescale 1ns / 1ps

module ipv4_emf_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_opcode,
   output logic                       req_ready,
   input  ipv4_emf_pkg::dp_status_type stat,
   output ipv4_emf_pkg::dp_cmd_type    cmd
);
   import ipv4_emf_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SUM  = 5'b00010,
      ST_FOLD = 5'b00100,
      ST_SCAN = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_opcode == OP_FWD) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_SUM;
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            state_in = stat.csum_ok ? ST_SCAN : ST_DONE;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/core/ipv4_emf_dp.sv]
`timescale 1ns / 1ps

module ipv4_emf_dp #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ipv4_emf_pkg::req_item_type  req_item,
   input  ipv4_emf_pkg::dp_cmd_type    cmd,
   output ipv4_emf_pkg::dp_status_type stat,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output ipv4_emf_pkg::rsp_item_type  rsp_item
);
   import ipv4_emf_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = IDX_W + 1;
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_ENTRIES);

   function automatic logic [19:0] sum10(input logic [63:0] w0, input logic [63:0] w1,
                                         input logic [31:0] dst);
      logic [19:0] s;
      s = 20'(w0[63:48]) + 20'(w0[47:32]) + 20'(w0[31:16]) + 20'(w0[15:0]);
      s = s + 20'(w1[63:48]) + 20'(w1[47:32]) + 20'(w1[31:16]) + 20'(w1[15:0]);
      s = s + 20'(dst[31:16]) + 20'(dst[15:0]);
      return s;
   endfunction

   function automatic logic [15:0] fold16(input logic [19:0] s);
      logic [16:0] f;
      f = {1'b0, s[15:0]} + {13'd0, s[19:16]};
      return f[15:0] + {15'd0, f[16]};
   endfunction

   logic [31:0]              mem_ip_ff  [TABLE_ENTRIES];
   logic [47:0]              mem_mac_ff [TABLE_ENTRIES];
   logic                     mem_vld_ff [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] written_ff;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [IDX_W-1:0] rd_addr;
   logic [31:0]      rd_ip_ff;
   logic [47:0]      rd_mac_ff;
   logic             rd_vld_ff;
   logic             rd_written_ff;
   logic [31:0]      e_ip;
   logic [47:0]      e_mac;
   logic             e_vld;

   logic [47:0] pk_eth_dst_ff;
   logic [63:0] pk_w0_ff;
   logic [63:0] pk_w1_ff;
   logic [31:0] pk_dst_ff;
   logic [7:0]  ttl_new;
   logic [63:0] w1_new;
   logic [19:0] sum_a_ff;
   logic [19:0] sum_b_ff;
   logic [7:0]  ttl_ff;
   logic        csum_bad_ff;
   logic [15:0] new_csum_ff;

   logic [CNT_W-1:0] issue_ff;
   logic             issue_go;
   logic             data_vld_ff;
   logic [IDX_W-1:0] data_idx_ff;
   logic             take;
   logic             match_found_ff;
   logic [IDX_W-1:0] match_idx_ff;
   logic [47:0]      match_mac_ff;
   logic             dflt_found_ff;
   logic [IDX_W-1:0] dflt_idx_ff;
   logic [47:0]      dflt_mac_ff;

   rsp_item_type result;
   rsp_item_type rsp_ff;
   logic         rsp_valid_ff;

   assign wr_en   = cmd.write && ({28'd0, req_item.entry_index} < 32'(TABLE_ENTRIES));
   assign wr_addr = IDX_W'(req_item.entry_index);
   assign rd_addr = issue_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ip_ff[wr_addr]  <= req_item.entry_ip;
         mem_mac_ff[wr_addr] <= req_item.entry_mac;
         mem_vld_ff[wr_addr] <= req_item.entry_valid;
      end
      rd_ip_ff      <= mem_ip_ff[rd_addr];
      rd_mac_ff     <= mem_mac_ff[rd_addr];
      rd_vld_ff     <= mem_vld_ff[rd_addr];
      rd_written_ff <= written_ff[rd_addr];
   end

   // A slot never written since reset reads as all zero and invalid.
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   assign e_ip  = rd_written_ff ? rd_ip_ff : 32'd0;
   assign e_mac = rd_written_ff ? rd_mac_ff : 48'd0;
   assign e_vld = rd_written_ff & rd_vld_ff;

   assign ttl_new = pk_w1_ff[63:56] - 8'd1;
   assign w1_new  = {ttl_new, pk_w1_ff[55:48], 16'h0000, pk_w1_ff[31:0]};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pk_eth_dst_ff <= req_item.eth_dst;
         pk_w0_ff      <= req_item.ip_word0;
         pk_w1_ff      <= req_item.ip_word1;
         pk_dst_ff     <= req_item.ip_dst;
      end
      if (cmd.sum) begin
         sum_a_ff <= sum10(pk_w0_ff, pk_w1_ff, pk_dst_ff);
         sum_b_ff <= sum10(pk_w0_ff, w1_new, pk_dst_ff);
         ttl_ff   <= ttl_new;
      end
      if (cmd.fold) begin
         csum_bad_ff <= !stat.csum_ok;
         new_csum_ff <= ~fold16(sum_b_ff);
      end
   end

   assign issue_go = cmd.scan && (issue_ff < LAST_CNT) && !match_found_ff;
   assign take     = data_vld_ff && !match_found_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff       <= '0;
         data_vld_ff    <= 1'b0;
         match_found_ff <= 1'b0;
         dflt_found_ff  <= 1'b0;
      end else if (cmd.capture) begin
         issue_ff       <= '0;
         data_vld_ff    <= 1'b0;
         match_found_ff <= 1'b0;
         dflt_found_ff  <= 1'b0;
      end else begin
         if (issue_go) begin
            issue_ff <= issue_ff + CNT_W'(1);
         end
         data_vld_ff <= issue_go;
         if (take && (e_ip == pk_dst_ff)) begin
            match_found_ff <= 1'b1;
         end
         if (take && e_vld) begin
            dflt_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_idx_ff <= rd_addr;
      if (take && (e_ip == pk_dst_ff)) begin
         match_idx_ff <= data_idx_ff;
         match_mac_ff <= e_mac;
      end
      if (take && e_vld) begin
         dflt_idx_ff <= data_idx_ff;
         dflt_mac_ff <= e_mac;
      end
   end

   assign stat.csum_ok   = (fold16(sum_a_ff) == 16'hFFFF);
   assign stat.scan_done = match_found_ff || ((issue_ff == LAST_CNT) && !data_vld_ff);
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      result = '0;
      if (csum_bad_ff) begin
         result.status = STATUS_BAD_CSUM;
      end else if (match_found_ff || dflt_found_ff) begin
         result.status       = STATUS_FWD;
         result.out_port     = match_found_ff ? 4'(match_idx_ff) : 4'(dflt_idx_ff);
         result.new_eth_dst  = match_found_ff ? match_mac_ff : dflt_mac_ff;
         result.new_eth_src  = pk_eth_dst_ff;
         result.new_ttl      = ttl_ff;
         result.new_checksum = new_csum_ff;
      end else begin
         result.status = STATUS_NO_ROUTE;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

[rtl/core/ipv4_emf_chk.sv]
`timescale 1ns / 1ps

module ipv4_emf_chk (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input ipv4_emf_pkg::req_item_type req_item,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input ipv4_emf_pkg::rsp_item_type rsp_item
);
   import ipv4_emf_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("result item changed or vanished while stalled");

   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.status != STATUS_FWD) |->
         (rsp_item.out_port == 4'd0) && (rsp_item.new_eth_dst == 48'd0) &&
         (rsp_item.new_eth_src == 48'd0) && (rsp_item.new_ttl == 8'd0) &&
         (rsp_item.new_checksum == 16'd0))
      else $error("dropped packet carries non-zero result fields");

   a_one_packet: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_item.opcode == OP_FWD) |=> !req_ready)
      else $error("new item taken while a packet is being looked up");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result item appeared without a packet being processed");

endmodule

bind ipv4_exact_match_forwarder_top ipv4_emf_chk u_chk (.*);

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import ipv4_emf_pkg::*;

   localparam int SLOTS = 16;
   localparam int RANDOM_ITEMS = 1950;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = SLOTS + 12;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_item_type rsp_item;

   logic [31:0]  route_ip [SLOTS];
   logic [47:0]  route_mac [SLOTS];
   logic         route_valid [SLOTS];
   rsp_item_type verdicts_due [$];
   int           fail_count = 0;
   int           burst_left = 0;
   int           cycle_count = 0;
   int           stall_mode = 0;

   ipv4_exact_match_forwarder_top #(
      .TABLE_ENTRIES(SLOTS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_item (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [15:0] fold_header(logic [63:0] w0, logic [63:0] w1,
                                               logic [31:0] dst);
      logic [31:0] s;
      s = 32'(dst[31:16]) + 32'(dst[15:0]);
      for (int k = 0; k < 4; k++) begin
         s += 32'(w0[48 - 16 * k +: 16]) + 32'(w1[48 - 16 * k +: 16]);
      end
      s = (s >> 16) + (s & 32'hFFFF);
      s = (s >> 16) + (s & 32'hFFFF);
      return s[15:0];
   endfunction

   function automatic rsp_item_type forward_packet(req_item_type pkt);
      rsp_item_type res;
      int           chosen;
      logic [7:0]   ttl;
      logic [63:0]  w1_new;
      res = '0;
      chosen = -1;
      if (fold_header(pkt.ip_word0, pkt.ip_word1, pkt.ip_dst) != 16'hFFFF) begin
         res.status = STATUS_BAD_CSUM;
         return res;
      end
      for (int k = SLOTS - 1; k >= 0; k--) begin
         if (route_ip[k] == pkt.ip_dst) chosen = k;
      end
      if (chosen < 0) begin
         for (int k = 0; k < SLOTS; k++) begin
            if (route_valid[k]) chosen = k;
         end
      end
      if (chosen < 0) begin
         res.status = STATUS_NO_ROUTE;
         return res;
      end
      ttl = pkt.ip_word1[63:56] - 8'd1;
      w1_new = {ttl, pkt.ip_word1[55:48], 16'h0000, pkt.ip_word1[31:0]};
      res.status = STATUS_FWD;
      res.out_port = chosen[3:0];
      res.new_eth_dst = route_mac[chosen];
      res.new_eth_src = pkt.eth_dst;
      res.new_ttl = ttl;
      res.new_checksum = ~fold_header(pkt.ip_word0, w1_new, pkt.ip_dst);
      return res;
   endfunction

   function automatic req_item_type random_item();
      req_item_type it;
      it.opcode = 1'($urandom_range(0, 1));
      it.entry_index = 4'($urandom_range(0, 15));
      it.entry_ip = $urandom;
      it.entry_mac = {16'($urandom), 32'($urandom)};
      it.entry_valid = 1'($urandom_range(0, 1));
      it.eth_dst = {16'($urandom), 32'($urandom)};
      it.eth_src = {16'($urandom), 32'($urandom)};
      it.ip_word0 = {32'($urandom), 32'($urandom)};
      it.ip_word1 = {32'($urandom), 32'($urandom)};
      it.ip_dst = $urandom;
      return it;
   endfunction

   function automatic req_item_type make_route(logic [3:0] slot, logic [31:0] ip,
                                               logic [47:0] mac, logic valid_mark);
      req_item_type it;
      it = random_item();
      it.opcode = OP_WRITE;
      it.entry_index = slot;
      it.entry_ip = ip;
      it.entry_mac = mac;
      it.entry_valid = valid_mark;
      return it;
   endfunction

   function automatic req_item_type make_packet(logic [31:0] dst, logic [7:0] ttl);
      req_item_type pkt;
      pkt = random_item();
      pkt.opcode = OP_FWD;
      pkt.ip_word1[63:56] = ttl;
      pkt.ip_word1[47:32] = 16'h0000;
      pkt.ip_dst = dst;
      pkt.ip_word1[47:32] = ~fold_header(pkt.ip_word0, pkt.ip_word1, pkt.ip_dst);
      return pkt;
   endfunction

   function automatic req_item_type flip_header_bit(req_item_type pkt);
      logic [159:0] hdr;
      hdr = {pkt.ip_word0, pkt.ip_word1, pkt.ip_dst};
      hdr[$urandom_range(0, 159)] ^= 1'b1;
      {pkt.ip_word0, pkt.ip_word1, pkt.ip_dst} = hdr;
      return pkt;
   endfunction

   function automatic logic [31:0] pick_dst();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return route_ip[$urandom_range(0, SLOTS - 1)];
      if (r < 70) return 32'h0000_0000;
      return $urandom;
   endfunction

   function automatic logic [7:0] pick_ttl();
      if ($urandom_range(0, 15) == 0) return 8'h00;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_item(req_item_type item);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_item <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      if (item.opcode == OP_WRITE) begin
         route_ip[item.entry_index] = item.entry_ip;
         route_mac[item.entry_index] = item.entry_mac;
         route_valid[item.entry_index] = item.entry_valid;
      end else begin
         verdicts_due.push_back(forward_packet(item));
      end
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      while (verdicts_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : check_results
      rsp_item_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdicts_due.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %h", $time, rsp_item);
            fail_count++;
         end else begin
            due = verdicts_due.pop_front();
            compare_field("status", 64'(due.status), 64'(rsp_item.status));
            compare_field("out_port", 64'(due.out_port), 64'(rsp_item.out_port));
            compare_field("new_eth_dst", 64'(due.new_eth_dst), 64'(rsp_item.new_eth_dst));
            compare_field("new_eth_src", 64'(due.new_eth_src), 64'(rsp_item.new_eth_src));
            compare_field("new_ttl", 64'(due.new_ttl), 64'(rsp_item.new_ttl));
            compare_field("new_checksum", 64'(due.new_checksum),
                          64'(rsp_item.new_checksum));
         end
      end
   end

   always @(negedge clock) begin
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 1) == 1);
         2: rsp_ready <= ($urandom_range(0, 7) == 0);
         default: rsp_ready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, verdicts_due.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic test_empty_table();
      req_item_type it;
      // Every slot still holds address zero, so 0.0.0.0 hits slot 0 although it is invalid.
      send_item(make_packet(32'h0000_0000, 8'd64));
      send_item(make_packet(32'hC0A8_0001, 8'd64));
      it = random_item();
      it.opcode = OP_FWD;
      it.ip_word0 = '0;
      it.ip_word1 = '0;
      it.ip_dst = '0;
      send_item(it);
      it.ip_word0 = '1;
      it.ip_word1 = '1;
      it.ip_dst = '1;
      send_item(it);
   endtask

   task automatic test_route_choice();
      send_item(make_route(4'd3, 32'h0A00_0001, 48'h0200_0000_0003, 1'b1));
      send_item(make_route(4'd7, 32'h0A00_0001, 48'h0200_0000_0007, 1'b1));
      send_item(make_route(4'd5, 32'h0A00_0005, 48'h0200_0000_0005, 1'b0));
      send_item(make_route(4'd15, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1));
      send_item(make_packet(32'h0A00_0001, 8'd10));
      send_item(make_packet(32'h0A00_0005, 8'd10));
      send_item(make_packet(32'h0B0B_0B0B, 8'd10));
      send_item(make_packet(32'h0000_0000, 8'd10));
      send_item(make_packet(32'hFFFF_FFFF, 8'd10));
      send_item(make_route(4'd15, 32'hFFFF_FFFF, 48'h0000_0000_0000, 1'b0));
      send_item(make_packet(32'h0B0B_0B0B, 8'd10));
      wait_drained();
   endtask

   task automatic test_ttl_and_checksum();
      req_item_type it;
      send_item(make_packet(32'h0A00_0001, 8'd0));
      send_item(make_packet(32'h0A00_0001, 8'd1));
      send_item(make_packet(32'h0A00_0001, 8'd255));
      it = make_packet(32'h0A00_0001, 8'd20);
      it.eth_dst = '1;
      it.eth_src = '0;
      send_item(it);
      it = make_packet(32'h0A00_0001, 8'd20);
      it.eth_dst = '0;
      it.eth_src = '1;
      send_item(it);
      send_item(flip_header_bit(make_packet(32'h0A00_0001, 8'd20)));
   endtask

   task automatic test_random_traffic(int count);
      int           r;
      req_item_type it;
      for (int n = 0; n < count; n++) begin
         if (n == count / 2) wait_drained();
         if ($urandom_range(0, 299) == 0) begin
            // Clearing every valid mark makes unmatched packets find no route.
            for (int k = 0; k < SLOTS; k++) begin
               send_item(make_route(4'(k), $urandom, {16'($urandom), 32'($urandom)}, 1'b0));
            end
         end
         r = $urandom_range(0, 99);
         if (r < 15) begin
            send_item(make_route(4'($urandom_range(0, 15)),
                                 ($urandom_range(0, 2) == 0) ?
                                    route_ip[$urandom_range(0, SLOTS - 1)] : $urandom,
                                 {16'($urandom), 32'($urandom)},
                                 1'($urandom_range(0, 3) != 0)));
         end else if (r < 80) begin
            send_item(make_packet(pick_dst(), pick_ttl()));
         end else if (r < 92) begin
            send_item(flip_header_bit(make_packet(pick_dst(), pick_ttl())));
         end else begin
            it = random_item();
            send_item(it);
         end
      end
   endtask

   initial begin
      for (int k = 0; k < SLOTS; k++) begin
         route_ip[k] = '0;
         route_mac[k] = '0;
         route_valid[k] = 1'b0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_route_choice();
      test_ttl_and_checksum();
      test_random_traffic(RANDOM_ITEMS);
      wait_drained();
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
